// ===== design/mmp_pkg.sv =====
// Shared constants, types and widths for the multinomial coefficient block.
package mmp_pkg;

  // Field widths.
  localparam int IN_W  = 17;
  localparam int VAL_W = 30;

  // Default table depth.
  localparam int MAX_N_DEF = 131072;

  // The prime modulus and the Barrett constant floor(2^60 / p).
  localparam logic [63:0] PRIME_64 = 64'd1000000007;
  localparam logic [VAL_W-1:0] PRIME = VAL_W'(PRIME_64);
  localparam logic [63:0] MU_64 = 64'h1000_0000_0000_0000 / PRIME_64;
  localparam logic [30:0] MU = 31'(MU_64);

  // Fermat exponent p-2, processed one bit per cell.
  localparam int EXP_BITS = 30;
  localparam logic [EXP_BITS-1:0] EXP_VAL = EXP_BITS'(PRIME_64 - 64'd2);

  // Data that rides along the exponent chain next to acc and base.
  typedef struct packed {
    logic [VAL_W-1:0] nf;
    logic             mis;
  } carry_t;

endpackage

// ===== design/mmp_modmul.sv =====
// Four-stage pipelined multiplier modulo the prime, with Barrett reduction.
module mmp_modmul #(
  parameter int SW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vin,
  input  logic [mmp_pkg::VAL_W-1:0]   a,
  input  logic [mmp_pkg::VAL_W-1:0]   b,
  input  logic [SW-1:0]               side_in,
  output logic                        vout,
  output logic [mmp_pkg::VAL_W-1:0]   r,
  output logic [SW-1:0]               side_out
);

  localparam logic [31:0] P32  = 32'(mmp_pkg::PRIME);
  localparam logic [31:0] P2X  = 32'(mmp_pkg::PRIME) << 1;

  logic          v1, v2, v3, v4;
  logic [59:0]   prod;
  logic [61:0]   t;
  logic [31:0]   xlo2;
  logic [31:0]   r3;
  logic [mmp_pkg::VAL_W-1:0] r4;
  logic [SW-1:0] s1, s2, s3, s4;
  logic [30:0]   q;

  assign q = t[61:31];

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= vin;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Product, quotient estimate, remainder estimate, final correction.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 60'(a) * 60'(b);
      s1   <= side_in;
      t    <= 62'(prod[59:29]) * 62'(mmp_pkg::MU);
      xlo2 <= prod[31:0];
      s2   <= s1;
      r3   <= xlo2 - 32'(64'(q) * 64'(P32));
      s3   <= s2;
      if (r3 >= P2X) begin
        r4 <= mmp_pkg::VAL_W'(r3 - P2X);
      end else if (r3 >= P32) begin
        r4 <= mmp_pkg::VAL_W'(r3 - P32);
      end else begin
        r4 <= mmp_pkg::VAL_W'(r3);
      end
      s4   <= s3;
    end
  end

  assign vout     = v4;
  assign r        = r4;
  assign side_out = s4;

endmodule

// ===== design/mmp_exp_cell.sv =====
// One cell of the exponent chain: handles one bit of the exponent p-2.
module mmp_exp_cell #(
  parameter bit USE_MUL = 1'b1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vin,
  input  logic [mmp_pkg::VAL_W-1:0] acc_in,
  input  logic [mmp_pkg::VAL_W-1:0] base_in,
  input  mmp_pkg::carry_t           pay_in,
  output logic                      vout,
  output logic [mmp_pkg::VAL_W-1:0] acc_out,
  output logic [mmp_pkg::VAL_W-1:0] base_out,
  output mmp_pkg::carry_t           pay_out
);

  generate
    if (USE_MUL) begin : g_mul
      logic [mmp_pkg::VAL_W-1:0] nf_d;
      logic                      mis_d;

      // Exponent bit set: acc takes one multiply by base.
      mmp_modmul #(.SW(mmp_pkg::VAL_W)) u_mul (
        .clk(clk), .rst(rst), .en(en), .vin(vin),
        .a(acc_in), .b(base_in), .side_in(pay_in.nf),
        .vout(vout), .r(acc_out), .side_out(nf_d)
      );

      // Base is squared for the next bit.
      mmp_modmul #(.SW(1)) u_sq (
        .clk(clk), .rst(rst), .en(en), .vin(vin),
        .a(base_in), .b(base_in), .side_in(pay_in.mis),
        .vout(), .r(base_out), .side_out(mis_d)
      );

      assign pay_out = '{nf: nf_d, mis: mis_d};
    end else begin : g_pass
      localparam int SW = mmp_pkg::VAL_W + $bits(mmp_pkg::carry_t);
      logic [SW-1:0] side_d;

      // Exponent bit clear: acc just rides along with the squaring.
      mmp_modmul #(.SW(SW)) u_sq (
        .clk(clk), .rst(rst), .en(en), .vin(vin),
        .a(base_in), .b(base_in), .side_in({acc_in, pay_in}),
        .vout(vout), .r(base_out), .side_out(side_d)
      );

      assign acc_out = side_d[SW-1 -: mmp_pkg::VAL_W];
      assign pay_out = side_d[$bits(mmp_pkg::carry_t)-1:0];
    end
  endgenerate

endmodule

// ===== design/mmp_table.sv =====
// Factorial table memory with its fill sequencer after reset.
module mmp_table #(
  parameter int MAX_N = mmp_pkg::MAX_N_DEF,
  parameter int AW    = $clog2(MAX_N)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ren,
  input  logic [AW-1:0]             raddr,
  output logic [mmp_pkg::VAL_W-1:0] rdata,
  output logic                      ready
);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;
  localparam logic [AW-1:0] LAST = AW'(MAX_N - 1);

  logic [mmp_pkg::VAL_W-1:0] mem [MAX_N];
  logic [1:0]                state;
  logic [AW-1:0]             idx;
  logic [mmp_pkg::VAL_W-1:0] prev;
  logic                      m_vout;
  logic [mmp_pkg::VAL_W-1:0] m_r;
  logic                      m_side;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [mmp_pkg::VAL_W-1:0] wdata;

  // Entry i is i times entry i-1.
  mmp_modmul #(.SW(1)) u_mm (
    .clk(clk), .rst(rst), .en(1'b1), .vin(state == ST_ISSUE),
    .a(mmp_pkg::VAL_W'(idx)), .b(prev), .side_in(1'b0),
    .vout(m_vout), .r(m_r), .side_out(m_side)
  );

  // Write port driven only by the fill.
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = m_r;
    case (state)
      ST_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = mmp_pkg::VAL_W'(1);
      end
      ST_WAIT: begin
        we = m_vout && !m_side;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Fill sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      idx   <= '0;
    end else begin
      case (state)
        ST_INIT: begin
          idx   <= AW'(1);
          state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (m_vout) begin
            if (idx == LAST) begin
              state <= ST_DONE;
            end else begin
              idx   <= idx + AW'(1);
              state <= ST_ISSUE;
            end
          end
        end
        default: begin
          state <= ST_DONE;
        end
      endcase
    end
  end

  // Previous factorial for the next step.
  always_ff @(posedge clk) begin
    if (we) begin
      prev <= wdata;
    end
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  assign ready = (state == ST_DONE);

endmodule

// ===== design/multinomial_mod_prime.sv =====
// Top level: n!/(c1!c2!c3!) mod 1000000007 with a factorial table and Fermat inverse chain.
//
//   Port group   Direction  Handshake          Payload
//   query        in         in_valid/in_ready  total_count, group_one, group_two, group_three
//   result       out        out_valid/out_ready arrangements, sum_mismatch
//
// The four factorials of an item come one after another from one table read port.
// Most of the pipeline is the 30 exponent cells of 4 stages each.
// After reset the table fills with in_ready low.
// A stalled result freezes the whole pipeline; one more query is held in a buffer.
module multinomial_mod_prime #(
  parameter int MAX_N = mmp_pkg::MAX_N_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mmp_pkg::IN_W-1:0]  total_count,
  input  logic [mmp_pkg::IN_W-1:0]  group_one,
  input  logic [mmp_pkg::IN_W-1:0]  group_two,
  input  logic [mmp_pkg::IN_W-1:0]  group_three,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mmp_pkg::VAL_W-1:0] arrangements,
  output logic                      sum_mismatch
);

  localparam int AW = $clog2(MAX_N);
  localparam int VW = mmp_pkg::VAL_W;
  localparam int NC = mmp_pkg::EXP_BITS;
  localparam logic [1:0] PH_N     = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;
  localparam logic [1:0] PH_THREE = 2'd3;

  function automatic logic [AW-1:0] sat_idx(input logic [mmp_pkg::IN_W-1:0] v);
    logic [AW-1:0] res;
    if (32'(v) >= 32'(MAX_N)) begin
      res = AW'(MAX_N - 1);
    end else begin
      res = AW'(v);
    end
    return res;
  endfunction

  logic                      en;
  logic                      fill_done;
  logic                      buf_valid;
  logic [mmp_pkg::IN_W-1:0]  buf_n, buf_c1, buf_c2, buf_c3;
  logic                      buf_mis;
  logic [mmp_pkg::IN_W+1:0]  grp_sum;
  logic                      seq_active;
  logic [1:0]                seq_ph;
  logic [AW-1:0]             seq_idx [4];
  logic                      seq_mis;
  logic                      load;
  logic [VW-1:0]             rdata;
  logic                      rd_v;
  logic [1:0]                rd_ph;
  logic                      rd_mis;
  logic                      g_valid;
  logic [VW-1:0]             g_nf, g_a, g_b, g_c;
  logic                      g_mis;
  logic                      m1_v;
  logic [VW-1:0]             m1_r;
  logic [VW+$bits(mmp_pkg::carry_t)-1:0] m1_side;
  logic                      m2_v;
  logic [VW-1:0]             m2_r;
  mmp_pkg::carry_t           m2_side;
  logic                      c_v   [NC+1];
  logic [VW-1:0]             c_acc [NC+1];
  logic [VW-1:0]             c_base[NC+1];
  mmp_pkg::carry_t           c_pay [NC+1];
  logic                      m3_v;
  logic [VW-1:0]             m3_r;
  logic                      m3_side;

  assign en       = !out_valid || out_ready;
  assign in_ready = !buf_valid && fill_done;
  assign grp_sum  = (mmp_pkg::IN_W+2)'(group_one) + (mmp_pkg::IN_W+2)'(group_two)
                  + (mmp_pkg::IN_W+2)'(group_three);
  assign load     = buf_valid && (!seq_active || seq_ph == PH_THREE);

  // Query buffer: takes an item while the pipeline is busy or stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      buf_valid <= 1'b1;
    end else if (en && load) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_n   <= total_count;
      buf_c1  <= group_one;
      buf_c2  <= group_two;
      buf_c3  <= group_three;
      buf_mis <= (grp_sum != (mmp_pkg::IN_W+2)'(total_count));
    end
  end

  // Read sequencer: four table reads per item, n first.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active <= 1'b0;
      seq_ph     <= PH_N;
    end else if (en) begin
      if (load) begin
        seq_active <= 1'b1;
        seq_ph     <= PH_N;
      end else if (seq_active) begin
        seq_ph <= seq_ph + 2'd1;
        if (seq_ph == PH_THREE) begin
          seq_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && load) begin
      seq_idx[0] <= sat_idx(buf_n);
      seq_idx[1] <= sat_idx(buf_c1);
      seq_idx[2] <= sat_idx(buf_c2);
      seq_idx[3] <= sat_idx(buf_c3);
      seq_mis    <= buf_mis;
    end
  end

  mmp_table #(.MAX_N(MAX_N), .AW(AW)) u_table (
    .clk(clk), .rst(rst), .ren(en && seq_active), .raddr(seq_idx[seq_ph]),
    .rdata(rdata), .ready(fill_done)
  );

  // Read tags follow the registered table data.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else if (en) begin
      rd_v <= seq_active;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_ph  <= seq_ph;
      rd_mis <= seq_mis;
    end
  end

  // Gather the four factorials of one item.
  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= rd_v && (rd_ph == PH_THREE);
    end
  end

  always_ff @(posedge clk) begin
    if (en && rd_v) begin
      case (rd_ph)
        PH_N:     g_nf <= rdata;
        PH_ONE:   g_a  <= rdata;
        PH_TWO:   g_b  <= rdata;
        PH_THREE: begin
          g_c   <= rdata;
          g_mis <= rd_mis;
        end
        default:  g_nf <= rdata;
      endcase
    end
  end

  // Denominator c1! * c2! * c3!; one inverse of it equals the product of the inverses.
  mmp_modmul #(.SW(VW + $bits(mmp_pkg::carry_t))) u_den1 (
    .clk(clk), .rst(rst), .en(en), .vin(g_valid),
    .a(g_a), .b(g_b), .side_in({g_c, g_nf, g_mis}),
    .vout(m1_v), .r(m1_r), .side_out(m1_side)
  );

  mmp_modmul #(.SW($bits(mmp_pkg::carry_t))) u_den2 (
    .clk(clk), .rst(rst), .en(en), .vin(m1_v),
    .a(m1_r), .b(m1_side[VW+$bits(mmp_pkg::carry_t)-1 -: VW]),
    .side_in(m1_side[$bits(mmp_pkg::carry_t)-1:0]),
    .vout(m2_v), .r(m2_r), .side_out(m2_side)
  );

  // Exponent chain: square-and-multiply, least significant bit in the first cell.
  assign c_v[0]    = m2_v;
  assign c_acc[0]  = VW'(1);
  assign c_base[0] = m2_r;
  assign c_pay[0]  = m2_side;

  generate
    for (genvar k = 0; k < NC; k++) begin : g_cell
      mmp_exp_cell #(.USE_MUL(mmp_pkg::EXP_VAL[k])) u_cell (
        .clk(clk), .rst(rst), .en(en), .vin(c_v[k]),
        .acc_in(c_acc[k]), .base_in(c_base[k]), .pay_in(c_pay[k]),
        .vout(c_v[k+1]), .acc_out(c_acc[k+1]), .base_out(c_base[k+1]),
        .pay_out(c_pay[k+1])
      );
    end
  endgenerate

  // Numerator times the inverse.
  mmp_modmul #(.SW(1)) u_final (
    .clk(clk), .rst(rst), .en(en), .vin(c_v[NC]),
    .a(c_pay[NC].nf), .b(c_acc[NC]), .side_in(c_pay[NC].mis),
    .vout(m3_v), .r(m3_r), .side_out(m3_side)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en && m3_v) begin
      arrangements <= m3_r;
      sum_mismatch <= m3_side;
    end
  end

  // Results are always reduced below the prime.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (arrangements < mmp_pkg::PRIME))
    else $error("result not reduced modulo the prime");

  // Nothing is accepted or produced while the table is still filling.
  a_fill_quiet: assert property (@(posedge clk) disable iff (rst)
    !fill_done |-> (!in_ready && !out_valid && !seq_active && !g_valid))
    else $error("activity during table fill");

  // Once an item is gathered, any read behind it starts a new item.
  a_gather_order: assert property (@(posedge clk) disable iff (rst)
    (g_valid && rd_v) |-> (rd_ph == PH_N))
    else $error("table reads out of order");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the multinomial coefficient modulo a prime block.
`timescale 1ns / 1ps

module tb_top;

  localparam int TABLE_DEPTH = mmp_pkg::MAX_N_DEF;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint P = 64'd1000000007;

  typedef struct packed {
    logic [mmp_pkg::VAL_W-1:0] arrangements;
    logic                      sum_mismatch;
  } count_result_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [mmp_pkg::IN_W-1:0]  total_count;
  logic [mmp_pkg::IN_W-1:0]  group_one;
  logic [mmp_pkg::IN_W-1:0]  group_two;
  logic [mmp_pkg::IN_W-1:0]  group_three;
  logic                      out_valid;
  logic                      out_ready;
  logic [mmp_pkg::VAL_W-1:0] arrangements;
  logic                      sum_mismatch;

  // Factorials mod p, in the same order the block fills its own table.
  logic [mmp_pkg::VAL_W-1:0] fact_mod [0:TABLE_DEPTH-1];
  count_result_t    pending_results [$];
  int               error_count = 0;
  longint           cycle_count = 0;
  bit               sender_no_gaps = 0;
  bit               receiver_no_stall = 0;

  multinomial_mod_prime DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .total_count(total_count), .group_one(group_one),
    .group_two(group_two), .group_three(group_three),
    .out_valid(out_valid), .out_ready(out_ready),
    .arrangements(arrangements), .sum_mismatch(sum_mismatch)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mul_p(logic [63:0] x, logic [63:0] y);
    return (x * y) % P;
  endfunction

  // Fermat inverse: raise to p-2, scanning exponent bits from the bottom.
  function automatic logic [63:0] fermat_inverse(logic [63:0] x);
    logic [63:0] acc;
    logic [63:0] base;
    logic [63:0] e;
    acc = 1;
    base = x % P;
    e = P - 2;
    for (int k = 0; k < mmp_pkg::EXP_BITS; k++) begin
      if (e[k]) acc = mul_p(acc, base);
      base = mul_p(base, base);
    end
    return acc;
  endfunction

  function automatic logic [63:0] fact_lookup(logic [63:0] idx);
    if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
    return {34'd0, fact_mod[idx]};
  endfunction

  function automatic count_result_t predict_count(logic [mmp_pkg::IN_W-1:0] n,
                                                  logic [mmp_pkg::IN_W-1:0] c1,
                                                  logic [mmp_pkg::IN_W-1:0] c2,
                                                  logic [mmp_pkg::IN_W-1:0] c3);
    count_result_t r;
    logic [63:0] ans;
    logic [mmp_pkg::IN_W+1:0] total;
    ans = mul_p(fact_lookup(n), fermat_inverse(fact_lookup(c1)));
    ans = mul_p(ans, fermat_inverse(fact_lookup(c2)));
    ans = mul_p(ans, fermat_inverse(fact_lookup(c3)));
    total = {2'b0, c1} + {2'b0, c2} + {2'b0, c3};
    r.arrangements = ans[mmp_pkg::VAL_W-1:0];
    r.sum_mismatch = (total != {2'b0, n});
    return r;
  endfunction

  // Send one item after a random gap; valid stays high through back-to-back items.
  task automatic send_query(int n, int c1, int c2, int c3);
    int gap;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    total_count <= mmp_pkg::IN_W'(n);
    group_one   <= mmp_pkg::IN_W'(c1);
    group_two   <= mmp_pkg::IN_W'(c2);
    group_three <= mmp_pkg::IN_W'(c3);
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_count(mmp_pkg::IN_W'(n), mmp_pkg::IN_W'(c1),
                                            mmp_pkg::IN_W'(c2), mmp_pkg::IN_W'(c3)));
  endtask

  // Well-formed query: the three groups add up to the total.
  task automatic send_matching(int n);
    int c1;
    int c2;
    c1 = $urandom_range(0, n);
    c2 = $urandom_range(0, n - c1);
    send_query(n, c1, c2, n - c1 - c2);
  endtask

  task automatic test_directed();
    send_query(0, 0, 0, 0);
    send_query(131071, 131071, 131071, 131071);
    send_query(131071, 131071, 0, 0);
    send_query(131071, 0, 131071, 0);
    send_query(131071, 0, 0, 131071);
    send_query(131071, 43690, 43690, 43691);
    send_query(10, 3, 3, 4);
    send_query(1, 1, 0, 0);
    send_query(5, 1, 1, 1);
    send_query(3, 5, 0, 0);
    send_query(0, 131071, 131071, 131071);
    send_query(131071, 1, 2, 3);
    send_query(12, 12, 12, 12);
    send_query(87381, 43690, 43691, 0);
    send_query(65536, 65536, 0, 0);
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    send_query($urandom_range(0, 131071), $urandom_range(0, 131071),
                            $urandom_range(0, 131071), $urandom_range(0, 131071));
        2:       send_query($urandom_range(0, 40), $urandom_range(0, 40),
                            $urandom_range(0, 40), $urandom_range(0, 40));
        3, 4:    send_matching($urandom_range(0, 131071));
        default: send_matching($urandom_range(0, 64));
      endcase
    end
  endtask

  // Sender holds off until every result has arrived, then resumes.
  task automatic test_drain_pause();
    test_random_mix(20);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
    test_random_mix(20);
  endtask

  task automatic test_back_to_back();
    sender_no_gaps = 1;
    receiver_no_stall = 1;
    test_random_mix(60);
    sender_no_gaps = 0;
    receiver_no_stall = 0;
  endtask

  // Check each accepted result and draw the stall before the next one.
  initial begin
    count_result_t want;
    int stall;
    stall = 0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected item: arrangements=%0d sum_mismatch=%0b",
                 arrangements, sum_mismatch);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (arrangements !== want.arrangements) begin
            $error("arrangements: expected %0d, got %0d", want.arrangements, arrangements);
            error_count++;
          end
          if (sum_mismatch !== want.sum_mismatch) begin
            $error("sum_mismatch: expected %0b, got %0b", want.sum_mismatch, sum_mismatch);
            error_count++;
          end
        end
        stall = receiver_no_stall ? 0 : $urandom_range(0, 14);
      end else if (stall > 0) begin
        stall--;
      end
      out_ready <= (stall == 0);
    end
  end

  // Run limit.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    total_count = '0;
    group_one = '0;
    group_two = '0;
    group_three = '0;
    fact_mod[0] = 1;
    for (int i = 1; i < TABLE_DEPTH; i++)
      fact_mod[i] = mmp_pkg::VAL_W'(mul_p(i, fact_mod[i-1]));
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_to_back();
    test_drain_pause();
    test_random_mix(430);

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
